@@ hw/rtl/tws_pkg.sv @@
package tws_pkg;

  // sequencer phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_SETUP   = 7'b0000010,
    PH_TX_LOW  = 7'b0000100,
    PH_TX_HIGH = 7'b0001000,
    PH_RX_HIGH = 7'b0010000,
    PH_RX_LOW  = 7'b0100000,
    PH_END     = 7'b1000000
  } phase_e;

  localparam logic [15:0] HalfPeriodReset = 16'd100;
  localparam logic [4:0]  CmdBits         = 5'd8;
  localparam logic [4:0]  TotalBits       = 5'd16;

  // pin-level input for one sequencer step
  typedef struct packed {
    logic       start_req;
    logic       operation;
    logic [7:0] command;
    logic [7:0] write_byte;
    logic       io_in;
  } in_item_t;

  // pin levels and status after one sequencer step
  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } out_item_t;

endpackage

@@ hw/rtl/tws_if.sv @@
interface tws_in_if import tws_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tws_out_if import tws_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tws_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tws_in_stage.sv @@
module tws_in_stage import tws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tws_in_if.sink   in_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_d, valid_q;
  in_item_t item_q;
  logic     fire;

  // room when empty or when the held beat moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign fire       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/tws_seq.sv @@
module tws_seq import tws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] half_period_i,
  output out_item_t   res_o
);

  phase_e      phase_d, phase_q;
  logic [4:0]  bit_count_d, bit_count_q;
  logic [15:0] out_shift_d, out_shift_q;
  logic [7:0]  in_shift_d, in_shift_q;
  logic [15:0] divider_d, divider_q;
  logic        is_read_d, is_read_q;
  logic [15:0] reload;
  logic [4:0]  count_inc;
  logic        running;
  logic        done;

  // next state for one step
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    divider_d   = divider_q;
    is_read_d   = is_read_q;
    done        = 1'b0;
    reload      = (half_period_i == 16'd0) ? 16'd1 : half_period_i;
    count_inc   = bit_count_q + 5'd1;
    running     = phase_q inside {PH_SETUP, PH_TX_LOW, PH_TX_HIGH, PH_RX_HIGH,
                                  PH_RX_LOW, PH_END};
    if (step_i) begin
      if (!running) begin
        phase_d = PH_IDLE;
        if (item_i.start_req) begin
          out_shift_d = {item_i.write_byte, item_i.command};
          is_read_d   = item_i.operation;
          bit_count_d = 5'd0;
          in_shift_d  = 8'd0;
          phase_d     = PH_SETUP;
          divider_d   = reload;
        end
      end else if (divider_q > 16'd1) begin
        divider_d = divider_q - 16'd1;
      end else begin
        divider_d = reload;
        case (phase_q)
          PH_SETUP: begin
            phase_d = PH_TX_LOW;
          end
          PH_TX_LOW: begin
            phase_d = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            out_shift_d = {1'b0, out_shift_q[15:1]};
            bit_count_d = count_inc;
            if (is_read_q && count_inc >= CmdBits) begin
              phase_d = PH_RX_HIGH;
            end else if (count_inc >= TotalBits) begin
              phase_d = PH_END;
            end else begin
              phase_d = PH_TX_LOW;
            end
          end
          PH_RX_HIGH: begin
            phase_d = PH_RX_LOW;
          end
          PH_RX_LOW: begin
            in_shift_d  = {item_i.io_in, in_shift_q[7:1]};
            bit_count_d = count_inc;
            if (count_inc >= TotalBits) begin
              phase_d = PH_END;
            end else begin
              phase_d = PH_RX_HIGH;
            end
          end
          default: begin
            phase_d   = PH_IDLE;
            divider_d = 16'd0;
            done      = 1'b1;
          end
        endcase
      end
    end
  end

  // pin levels follow the updated state
  always_comb begin
    res_o.chip_enable  = phase_d inside {PH_SETUP, PH_TX_LOW, PH_TX_HIGH, PH_RX_HIGH,
                                         PH_RX_LOW};
    res_o.serial_clock = phase_d inside {PH_TX_HIGH, PH_RX_HIGH};
    res_o.io_drive     = phase_d inside {PH_TX_LOW, PH_TX_HIGH};
    res_o.io_out       = res_o.io_drive && out_shift_d[0];
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.read_byte    = done ? in_shift_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= 5'd0;
      out_shift_q <= 16'd0;
      in_shift_q  <= 8'd0;
      divider_q   <= 16'd0;
      is_read_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      out_shift_q <= out_shift_d;
      in_shift_q  <= in_shift_d;
      divider_q   <= divider_d;
      is_read_q   <= is_read_d;
    end
  end

`ifndef SYNTH
  // phase holds while the divider is still counting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q != PH_IDLE && divider_q > 16'd1 |=> phase_q == $past(phase_q))
    else $error("phase left before divider expired");

  // done only on the return to idle with the link quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> !res_o.busy_res && !res_o.chip_enable && !res_o.io_drive)
    else $error("done while link active");

  // no beat, no state change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(bit_count_q) && $stable(divider_q))
    else $error("state moved without a beat");
`endif

endmodule

@@ hw/rtl/tws_out_stage.sv @@
module tws_out_stage import tws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t res_i,
  tws_out_if.source out_o,
  output logic      free_o
);

  logic      valid_d, valid_q;
  out_item_t res_q;

  // register can take a new result when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = res_q;

endmodule

@@ hw/rtl/three_wire_serial_master.sv @@
// an accepted beat is held in the input register, then its result
// in the result register; throughput: one beat per cycle while out_o is
// ready, set by the registers that part the sequencer from both channels
// reset: asynchronous active low; idle, link released, half period 100
// config beats are taken every cycle and apply from the next phase entry
module three_wire_serial_master import tws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tws_in_if.sink    in_i,
  tws_out_if.source out_o,
  tws_cfg_if.sink   cfg_i
);

  logic        s1_valid;
  in_item_t    s1_item;
  logic        out_free;
  logic        step;
  out_item_t   res;
  logic [15:0] half_period_q;

  // half period register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
    end else if (cfg_i.valid) begin
      half_period_q <= cfg_i.data;
    end
  end

  tws_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (out_free),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  // a held beat steps the sequencer once the result register has room
  assign step = s1_valid && out_free;

  tws_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (s1_item),
    .half_period_i (half_period_q),
    .res_o         (res)
  );

  tws_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .res_i  (res),
    .out_o  (out_o),
    .free_o (out_free)
  );

endmodule
